>>> hdl/tfr_pkg.sv
// Shared types, codes and field layout for the telemetry frame receiver.
package tfr_pkg;

  localparam int FIELD_COUNT = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int POS_TYPE    = 2;
  localparam int POS_LENGTH  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL          = 3'd4;

  // Result status codes
  localparam logic [1:0] STATUS_GOOD = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // Byte offset of each field in the frame; fields sit back to back from offset 4
  localparam logic [7:0] FIELD_OFFSET [FIELD_COUNT] = '{
    8'd4, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14, 8'd16, 8'd20,
    8'd24, 8'd28, 8'd30, 8'd34, 8'd38, 8'd42, 8'd46, 8'd50
  };

  // Bit k set: field k is a 16-bit integer, else a 32-bit float pattern
  localparam logic [FIELD_COUNT-1:0] FIELD_SHORT = 16'b0000_0010_0011_1111;

  typedef struct packed {
    logic take_first;   // latch first header byte
    logic take_second;  // latch second header byte, start collecting
    logic collect;      // store one frame byte
    logic frame_good;   // count good frame, start field readout
    logic frame_bad;    // count bad frame, load bad result
    logic rd;           // read frame memory at current field byte
    logic shift;        // shift read byte into field assembly
    logic next_byte;    // advance to next byte of field
    logic load_field;   // load assembled field into output register
    logic next_field;   // advance to next field
  } tfr_cmd_t;

  typedef struct packed {
    logic is_first;
    logic is_second;
    logic pos_last;
    logic frame_ok;
    logic field_done;
    logic last_field;
    logic out_busy;
    logic out_taken;
  } tfr_sts_t;

endpackage

>>> hdl/tfr_datapath.sv
// Datapath: config registers, frame memory, checks, field assembly and output register.
module tfr_datapath #(
  parameter int FRAME_BYTES = 56
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        out_stall,
  input  tfr_pkg::tfr_cmd_t           cmd,
  output tfr_pkg::tfr_sts_t           sts,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [3:0]                  out_field_index,
  output logic [31:0]                 out_field_value,
  output logic                        out_last_of_run,
  output logic [31:0]                 out_good_frames,
  output logic [31:0]                 out_bad_frames
);
  import tfr_pkg::*;

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_BYTES - 1);
  localparam logic [ADDR_W-1:0] CHK_POS  = ADDR_W'(FRAME_BYTES - 2);

  logic [7:0] hdr_first_cfg_r, hdr_second_cfg_r, type_cfg_r, len_cfg_r, tail_cfg_r;
  logic [7:0] hdr0_r, hdr1_r, type_r, len_r, chk_r, sum_r;
  logic [ADDR_W-1:0] pos_r;
  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rdata_r;
  logic [3:0] fld_r;
  logic [1:0] byte_r;
  logic [31:0] asm_r, asm_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0] field_val;
  logic fld_short;

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_index_r;
  logic [31:0] out_value_r;
  logic        out_last_r;
  logic [31:0] good_r, bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_first_cfg_r  <= '0;
      hdr_second_cfg_r <= '0;
      type_cfg_r       <= '0;
      len_cfg_r        <= '0;
      tail_cfg_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  hdr_first_cfg_r  <= cfg_wdata;
        REG_HEADER_SECOND: hdr_second_cfg_r <= cfg_wdata;
        REG_FRAME_TYPE:    type_cfg_r       <= cfg_wdata;
        REG_LENGTH:        len_cfg_r        <= cfg_wdata;
        REG_TAIL:          tail_cfg_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Header, type, length and checksum are kept in registers so the frame
  // check needs no memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      if (cmd.take_second) begin
        pos_r <= ADDR_W'(POS_TYPE);
      end else if (cmd.collect && !sts.pos_last) begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_first) hdr0_r <= in_rx_byte;
    if (cmd.take_second) begin
      hdr1_r <= in_rx_byte;
      sum_r  <= '0;
    end
    if (cmd.collect) begin
      if (pos_r == ADDR_W'(POS_TYPE))   type_r <= in_rx_byte;
      if (pos_r == ADDR_W'(POS_LENGTH)) len_r  <= in_rx_byte;
      if (pos_r == CHK_POS)             chk_r  <= in_rx_byte;
      if (pos_r < CHK_POS)              sum_r  <= sum_r + in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.collect) mem[pos_r] <= in_rx_byte;
  end

  assign rd_addr = ADDR_W'(FIELD_OFFSET[fld_r]) + ADDR_W'(byte_r);

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata_r <= mem[rd_addr];
  end

  // Little-endian: each new byte enters at the top
  assign asm_nxt   = {rdata_r, asm_r[31:8]};
  assign fld_short = FIELD_SHORT[fld_r];
  assign field_val = fld_short ? {{16{asm_nxt[31]}}, asm_nxt[31:16]} : asm_nxt;

  always_ff @(posedge clk) begin
    if (cmd.shift) asm_r <= asm_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_r  <= '0;
      byte_r <= '0;
    end else begin
      if (cmd.frame_good) begin
        fld_r  <= '0;
        byte_r <= '0;
      end else if (cmd.next_field) begin
        fld_r  <= fld_r + 1'b1;
        byte_r <= '0;
      end else if (cmd.next_byte) begin
        byte_r <= byte_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
    end else begin
      if (cmd.frame_good) good_r <= good_r + 1'b1;
      if (cmd.frame_bad)  bad_r  <= bad_r + 1'b1;
      if (cmd.frame_bad || cmd.load_field) begin
        out_valid_r <= 1'b1;
      end else if (sts.out_taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.frame_bad) begin
      out_status_r <= STATUS_BAD;
      out_index_r  <= '0;
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.load_field) begin
      out_status_r <= STATUS_GOOD;
      out_index_r  <= fld_r;
      out_value_r  <= field_val;
      out_last_r   <= sts.last_field;
    end
  end

  always_comb begin
    sts.is_first   = (in_rx_byte == hdr_first_cfg_r);
    sts.is_second  = (in_rx_byte == hdr_second_cfg_r);
    sts.pos_last   = (pos_r == LAST_POS);
    sts.frame_ok   = (hdr0_r == hdr_first_cfg_r) && (hdr1_r == hdr_second_cfg_r) &&
                     (type_r == type_cfg_r) && (len_r == len_cfg_r) &&
                     (in_rx_byte == tail_cfg_r) && (sum_r == chk_r);
    sts.field_done = fld_short ? (byte_r == 2'd1) : (byte_r == 2'd3);
    sts.last_field = (fld_r == 4'(FIELD_COUNT - 1));
    sts.out_busy   = out_valid_r;
    sts.out_taken  = out_valid_r && !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_field_index = out_index_r;
  assign out_field_value = out_value_r;
  assign out_last_of_run = out_last_r;
  // Counters change only while the output register is empty, so they are
  // steady for every result they accompany.
  assign out_good_frames = good_r;
  assign out_bad_frames  = bad_r;

endmodule

>>> hdl/tfr_ctrl.sv
// Controller: header hunt, frame collection and field readout sequencing.
module tfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tfr_pkg::tfr_sts_t  sts,
  output tfr_pkg::tfr_cmd_t  cmd
);
  import tfr_pkg::*;

  typedef enum logic [5:0] {
    ST_HUNT    = 6'b000001,
    ST_SYNC    = 6'b000010,
    ST_COLLECT = 6'b000100,
    ST_READ    = 6'b001000,
    ST_CAPTURE = 6'b010000,
    ST_EMIT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   rx_open;
  logic   acc;

  assign rx_open  = (state_r == ST_HUNT) || (state_r == ST_SYNC) || (state_r == ST_COLLECT);
  // Hold off the frame-completing byte while an earlier result is still pending
  assign in_stall = !rx_open || ((state_r == ST_COLLECT) && sts.pos_last && sts.out_busy);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT: begin
        if (acc && sts.is_first) begin
          cmd.take_first = 1'b1;
          state_nxt      = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (acc) begin
          if (sts.is_second) begin
            cmd.take_second = 1'b1;
            state_nxt       = ST_COLLECT;
          end else if (sts.is_first) begin
            cmd.take_first = 1'b1;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_COLLECT: begin
        if (acc) begin
          cmd.collect = 1'b1;
          if (sts.pos_last) begin
            if (sts.frame_ok) begin
              cmd.frame_good = 1'b1;
              state_nxt      = ST_READ;
            end else begin
              cmd.frame_bad = 1'b1;
              state_nxt     = ST_HUNT;
            end
          end
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd.shift = 1'b1;
        if (sts.field_done) begin
          cmd.load_field = 1'b1;
          state_nxt      = sts.last_field ? ST_HUNT : ST_EMIT;
        end else begin
          cmd.next_byte = 1'b1;
          state_nxt     = ST_READ;
        end
      end
      ST_EMIT: begin
        if (sts.out_taken) begin
          cmd.next_field = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/telemetry_frame_receiver.sv
// Top level of the telemetry frame receiver: controller plus datapath.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, in_rx_byte               | byte in
//  out     | out_valid, out_stall, out_status, out_field_*,| result out
//          | out_last_of_run, out_good_frames, out_bad_frames |
//  cfg     | cfg_we, cfg_index, cfg_wdata                 | write only
//
// One byte per cycle is taken while hunting and collecting a frame.
// A good frame then holds the input while its fields are read out: each field byte is
// read from the single-port frame memory (50 field bytes) and shifted in, with a
// handoff after each of the first fifteen fields that waits out any out_stall time;
// the input reopens once the last field loads.
// A bad frame does not hold the input; its completing byte waits only if an
// earlier result is still pending. Reset is synchronous; the frame memory is not cleared.
module telemetry_frame_receiver #(
  parameter int FRAME_BYTES = 56
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [3:0]                     out_field_index,
  output logic [31:0]                    out_field_value,
  output logic                           out_last_of_run,
  output logic [31:0]                    out_good_frames,
  output logic [31:0]                    out_bad_frames
);
  import tfr_pkg::*;

  tfr_cmd_t cmd;
  tfr_sts_t sts;

  tfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_rx_byte      (in_rx_byte),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_field_index (out_field_index),
    .out_field_value (out_field_value),
    .out_last_of_run (out_last_of_run),
    .out_good_frames (out_good_frames),
    .out_bad_frames  (out_bad_frames)
  );

endmodule

>>> hdl/tfr_checker.sv
// Port-level checks for the telemetry frame receiver, bound to the top level.
module tfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [3:0]  out_field_index,
  input logic [31:0] out_field_value,
  input logic        out_last_of_run,
  input logic [31:0] out_good_frames,
  input logic [31:0] out_bad_frames
);
  import tfr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_field_value) &&
                              $stable(out_field_index) && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_GOOD) || (out_status == STATUS_BAD))
    else $error("result with unknown status");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_BAD) |->
      out_last_of_run && (out_field_index == 4'd0) && (out_field_value == 32'd0))
    else $error("bad-frame result malformed");

  a_last_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_GOOD) |->
      (out_last_of_run == (out_field_index == 4'(FIELD_COUNT - 1))))
    else $error("run end flag disagrees with field index");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (out_good_frames == $past(out_good_frames) ||
              out_good_frames == $past(out_good_frames) + 32'd1) &&
             (out_bad_frames == $past(out_bad_frames) ||
              out_bad_frames == $past(out_bad_frames) + 32'd1))
    else $error("frame counter jumped");

endmodule

bind telemetry_frame_receiver tfr_checker u_tfr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_field_index (out_field_index),
  .out_field_value (out_field_value),
  .out_last_of_run (out_last_of_run),
  .out_good_frames (out_good_frames),
  .out_bad_frames  (out_bad_frames)
);
